>>> sv/via_pkg.sv
// Shared types and constants for the versatile interface adapter.
// Depends on nothing. The divider and the top level import it.
`timescale 1ns / 1ps
`default_nettype none
package via_pkg;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_CA1   = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    REG_ORB       = 4'd0,
    REG_ORA       = 4'd1,
    REG_DIR_B     = 4'd2,
    REG_DIR_A     = 4'd3,
    REG_T1_LO     = 4'd4,
    REG_T1_HI     = 4'd5,
    REG_T1_LAT_LO = 4'd6,
    REG_T1_LAT_HI = 4'd7,
    REG_T2_LO     = 4'd8,
    REG_T2_HI     = 4'd9,
    REG_SR        = 4'd10,
    REG_ACR       = 4'd11,
    REG_PCR       = 4'd12,
    REG_IFR       = 4'd13,
    REG_IER       = 4'd14,
    REG_ORA_NH    = 4'd15
  } reg_e;

  // Flag bit positions within the 7 stored flag bits
  localparam int unsigned FlagCa1 = 1;
  localparam int unsigned FlagCb1 = 4;
  localparam int unsigned FlagT2  = 5;
  localparam int unsigned FlagT1  = 6;

  localparam int unsigned AcrFreeRun = 6;
  localparam int unsigned DivSteps   = 8;

  // Divider status toward the sequencer
  typedef struct packed {
    logic        done;
    logic [15:0] rem;
  } div_st_t;

endpackage
`default_nettype wire

>>> sv/via_div.sv
// Iterative remainder unit: 8-bit dividend modulo a 16-bit divisor.
// One restoring step per cycle. Uses via_pkg.
`timescale 1ns / 1ps
`default_nettype none
module via_div
  import via_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [7:0]  dividend_i,
  input  wire logic [15:0] divisor_i,
  output div_st_t          st_o
);

  logic        busy_q;
  logic [3:0]  cnt_q;
  logic [15:0] rem_q;
  logic [7:0]  dvd_q;
  logic [15:0] dsr_q;
  logic [16:0] shifted;

  // Shift in the next dividend bit
  assign shifted = {rem_q, dvd_q[7]};

  // Run one compare and subtract per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 4'(DivSteps);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 4'd1;
      if (cnt_q == 4'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[6:0], 1'b0};
      if (shifted >= {1'b0, dsr_q}) begin
        rem_q <= 16'(shifted - {1'b0, dsr_q});
      end else begin
        rem_q <= shifted[15:0];
      end
    end
  end

  assign st_o.done = !busy_q;
  assign st_o.rem  = rem_q;

endmodule
`default_nettype wire

>>> sv/versatile_interface_adapter.sv
// Top level of the versatile interface adapter: register file, timers, flags.
// Depends on via_pkg and via_div.
//
//   channel | signals                                   | direction
//   in      | in_valid_i, in_stall_o, cmd_i .. ca1_level_i | into block
//   out     | out_valid_o, out_stall_i, read_data_o, irq_out_o | out of block
//
// Reads, writes, CA1 updates and ticks without a free-running reload are
// handled in the accepting cycle. A free-running reload of timer 1 passes
// the accepting cycle, 8 via_div steps and a write-back on out_free.
// Reset clears all state at once; no sweep follows.
// A result held by out_stall_i blocks the next transaction until taken.
`timescale 1ns / 1ps
`default_nettype none
module versatile_interface_adapter
  import via_pkg::*;
#(
  parameter int unsigned MAX_TICK_CYCLES = 255
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] cmd_i,
  input  wire logic [3:0] reg_index_i,
  input  wire logic [7:0] write_data_i,
  input  wire logic [7:0] port_a_pins_i,
  input  wire logic [7:0] port_b_pins_i,
  input  wire logic [7:0] tick_cycles_i,
  input  wire logic       ca1_level_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      read_data_o,
  output logic            irq_out_o
);

  localparam logic [16:0] MaxTick = 17'(MAX_TICK_CYCLES);

  typedef enum logic {
    S_IDLE,
    S_DIV
  } state_e;

  state_e      state_q, state_d;
  logic [7:0]  pa_out_q, pa_out_d, pb_out_q, pb_out_d;
  logic [7:0]  dir_a_q, dir_a_d, dir_b_q, dir_b_d;
  logic [15:0] t1_cnt_q, t1_cnt_d, t1_lat_q, t1_lat_d, t2_cnt_q, t2_cnt_d;
  logic [7:0]  t2_lat_q, t2_lat_d, sr_q, sr_d, acr_q, acr_d, pcr_q, pcr_d;
  logic [6:0]  flags_q, flags_d, ien_q, ien_d;
  logic        t1_fired_q, t1_fired_d, ca1_q, ca1_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  rd_q, rd_d;
  logic        irq_q, irq_d;

  logic        accept, out_free, div_start;
  logic [7:0]  cyc, porta, over;
  logic [15:0] period;
  div_st_t     div_st;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // Saturate the tick length
  assign cyc = ({9'd0, tick_cycles_i} > MaxTick) ? MaxTick[7:0] : tick_cycles_i;
  assign porta = (pa_out_q & dir_a_q) | (port_a_pins_i & ~dir_a_q);
  assign period = (t1_lat_q == 16'hffff) ? 16'd1 : 16'(t1_lat_q + 16'd1);
  assign over = cyc - t1_cnt_q[7:0];

  via_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (over),
    .divisor_i  (period),
    .st_o       (div_st)
  );

  // Next-state logic for the register file and sequencer
  always_comb begin
    state_d = state_q;
    pa_out_d = pa_out_q; pb_out_d = pb_out_q;
    dir_a_d = dir_a_q; dir_b_d = dir_b_q;
    t1_cnt_d = t1_cnt_q; t1_lat_d = t1_lat_q; t2_cnt_d = t2_cnt_q;
    t2_lat_d = t2_lat_q; sr_d = sr_q; acr_d = acr_q; pcr_d = pcr_q;
    flags_d = flags_q; ien_d = ien_q;
    t1_fired_d = t1_fired_q; ca1_d = ca1_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_d = rd_q;
    irq_d = irq_q;
    div_start = 1'b0;

    if (state_q == S_DIV) begin
      // Finish the reload once via_div is done and the result slot is free
      if (div_st.done && out_free) begin
        t1_cnt_d = 16'(period - div_st.rem);
        flags_d[FlagT1] = 1'b1;
        out_valid_d = 1'b1;
        rd_d = '0;
        irq_d = |(flags_d & ien_d);
        state_d = S_IDLE;
      end
    end else if (accept) begin
      out_valid_d = 1'b1;
      rd_d = '0;
      case (cmd_e'(cmd_i))
        CMD_READ: begin
          case (reg_e'(reg_index_i))
            REG_ORB: begin
              rd_d = (pb_out_q & dir_b_q) | (port_b_pins_i & ~dir_b_q);
              flags_d[FlagCb1] = 1'b0;
            end
            REG_ORA: begin
              rd_d = porta;
              flags_d[FlagCa1] = 1'b0;
            end
            REG_DIR_B: rd_d = dir_b_q;
            REG_DIR_A: rd_d = dir_a_q;
            REG_T1_LO: begin
              rd_d = t1_cnt_q[7:0];
              flags_d[FlagT1] = 1'b0;
            end
            REG_T1_HI: rd_d = t1_cnt_q[15:8];
            REG_T1_LAT_LO: rd_d = t1_lat_q[7:0];
            REG_T1_LAT_HI: rd_d = t1_lat_q[15:8];
            REG_T2_LO: begin
              rd_d = t2_cnt_q[7:0];
              flags_d[FlagT2] = 1'b0;
            end
            REG_T2_HI: rd_d = t2_cnt_q[15:8];
            REG_SR:   rd_d = sr_q;
            REG_ACR:  rd_d = acr_q;
            REG_PCR:  rd_d = pcr_q;
            REG_IFR:  rd_d = {|(flags_q & ien_q), flags_q};
            REG_IER:  rd_d = {1'b1, ien_q};
            default:  rd_d = porta;
          endcase
        end
        CMD_WRITE: begin
          case (reg_e'(reg_index_i))
            REG_ORB: begin
              pb_out_d = write_data_i;
              flags_d[FlagCb1] = 1'b0;
            end
            REG_ORA, REG_ORA_NH: begin
              pa_out_d = write_data_i;
              flags_d[FlagCa1] = 1'b0;
            end
            REG_DIR_B: dir_b_d = write_data_i;
            REG_DIR_A: dir_a_d = write_data_i;
            REG_T1_LO, REG_T1_LAT_LO: t1_lat_d = {t1_lat_q[15:8], write_data_i};
            REG_T1_HI: begin
              t1_lat_d = {write_data_i, t1_lat_q[7:0]};
              t1_cnt_d = {write_data_i, t1_lat_q[7:0]};
              t1_fired_d = 1'b0;
              flags_d[FlagT1] = 1'b0;
            end
            REG_T1_LAT_HI: begin
              t1_lat_d = {write_data_i, t1_lat_q[7:0]};
              flags_d[FlagT1] = 1'b0;
            end
            REG_T2_LO: t2_lat_d = write_data_i;
            REG_T2_HI: begin
              t2_cnt_d = {write_data_i, t2_lat_q};
              flags_d[FlagT2] = 1'b0;
            end
            REG_SR:  sr_d = write_data_i;
            REG_ACR: acr_d = write_data_i;
            REG_PCR: pcr_d = write_data_i;
            REG_IFR: flags_d = flags_q & ~write_data_i[6:0];
            default: begin
              if (write_data_i[7]) begin
                ien_d = ien_q | write_data_i[6:0];
              end else begin
                ien_d = ien_q & ~write_data_i[6:0];
              end
            end
          endcase
        end
        CMD_TICK: begin
          // Timer 2 counts on and flags on reaching zero
          if (t2_cnt_q <= {8'd0, cyc}) begin
            flags_d[FlagT2] = 1'b1;
          end
          t2_cnt_d = 16'(t2_cnt_q - {8'd0, cyc});
          if (t1_cnt_q <= {8'd0, cyc}) begin
            if (acr_q[AcrFreeRun]) begin
              // Fold the overshoot in the divider
              div_start = 1'b1;
              out_valid_d = 1'b0;
              state_d = S_DIV;
            end else begin
              t1_cnt_d = 16'(t1_cnt_q - {8'd0, cyc});
              if (!t1_fired_q) begin
                t1_fired_d = 1'b1;
                flags_d[FlagT1] = 1'b1;
              end
            end
          end else begin
            t1_cnt_d = 16'(t1_cnt_q - {8'd0, cyc});
          end
        end
        default: begin
          if (ca1_level_i != ca1_q) begin
            ca1_d = ca1_level_i;
            if (ca1_level_i == pcr_q[0]) begin
              flags_d[FlagCa1] = 1'b1;
            end
          end
        end
      endcase
      irq_d = |(flags_d & ien_d);
    end
  end

  // Hold the register file, control state and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pa_out_q <= '0; pb_out_q <= '0; dir_a_q <= '0; dir_b_q <= '0;
      t1_cnt_q <= '0; t1_lat_q <= '0; t2_cnt_q <= '0; t2_lat_q <= '0;
      sr_q <= '0; acr_q <= '0; pcr_q <= '0; flags_q <= '0; ien_q <= '0;
      t1_fired_q <= 1'b0; ca1_q <= 1'b0;
      out_valid_q <= 1'b0;
      rd_q <= '0;
      irq_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pa_out_q <= pa_out_d; pb_out_q <= pb_out_d;
      dir_a_q <= dir_a_d; dir_b_q <= dir_b_d;
      t1_cnt_q <= t1_cnt_d; t1_lat_q <= t1_lat_d; t2_cnt_q <= t2_cnt_d;
      t2_lat_q <= t2_lat_d; sr_q <= sr_d; acr_q <= acr_d; pcr_q <= pcr_d;
      flags_q <= flags_d; ien_q <= ien_d;
      t1_fired_q <= t1_fired_d; ca1_q <= ca1_d;
      out_valid_q <= out_valid_d;
      rd_q <= rd_d;
      irq_q <= irq_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = rd_q;
  assign irq_out_o   = irq_q;

endmodule
`default_nettype wire

>>> sv/via_checker.sv
// Port-level checks for versatile_interface_adapter, with its bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module via_port_checks (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] read_data_o,
  input wire logic       irq_out_o
);

  // An accepted transaction yields a result or keeps the input stalled
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (out_valid_o || in_stall_o))
    else $error("accepted transaction neither produced a result nor stalled");

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(read_data_o) && $stable(irq_out_o)))
    else $error("stalled result changed");

  // A held result blocks new input
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input accepted while result is held");

  // No result during reset
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind versatile_interface_adapter via_port_checks u_via_port_checks (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .read_data_o (read_data_o),
  .irq_out_o   (irq_out_o)
);
`default_nettype wire

>>> tb/via_checker.sv
// Checker for the versatile interface adapter: watches both channels, predicts
// each result from its own copy of the register state and compares in order.
// Depends on via_pkg.
`timescale 1ns / 1ps
module via_checker
  import via_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_stall_i,
  input  wire logic [1:0] cmd_i,
  input  wire logic [3:0] reg_index_i,
  input  wire logic [7:0] write_data_i,
  input  wire logic [7:0] port_a_pins_i,
  input  wire logic [7:0] port_b_pins_i,
  input  wire logic [7:0] tick_cycles_i,
  input  wire logic       ca1_level_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_stall_i,
  input  wire logic [7:0] read_data_i,
  input  wire logic       irq_out_i,
  output int              errors_o,
  output int              pending_o,
  output int              results_o
);

  localparam int unsigned MaxTick = 255;

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
  } via_result_t;

  via_result_t expected_q[$];

  logic [7:0]  pa_out, pb_out, ddra, ddrb, t2_lo_latch, sreg, acr, pcr, ifr;
  logic [6:0]  ier;
  logic [15:0] t1_cnt, t1_latch, t2_cnt;
  logic        t1_done, ca1_prev;

  // Recompute the composite interrupt bit
  function automatic void update_irq();
    ifr[7] = |(ifr[6:0] & ier);
  endfunction

  function automatic void drop_flags(logic [7:0] bits);
    ifr = ifr & ~bits;
    update_irq();
  endfunction

  function automatic void advance_timers(logic [7:0] n);
    int unsigned cyc, period, over;
    cyc = (n > MaxTick) ? MaxTick : n;
    if (t1_cnt <= cyc) begin
      if (acr[AcrFreeRun]) begin
        period = (t1_latch + 1) & 16'hffff;
        if (period == 0) period = 1;
        over = cyc - t1_cnt;
        t1_cnt = 16'(period - (over % period));
        ifr[FlagT1] = 1'b1;
      end else begin
        t1_cnt = 16'(t1_cnt - cyc);
        if (!t1_done) begin
          t1_done = 1'b1;
          ifr[FlagT1] = 1'b1;
        end
      end
    end else begin
      t1_cnt = 16'(t1_cnt - cyc);
    end
    if (t2_cnt <= cyc) ifr[FlagT2] = 1'b1;
    t2_cnt = 16'(t2_cnt - cyc);
    update_irq();
  endfunction

  function automatic logic [7:0] bus_read(logic [3:0] r, logic [7:0] pa, logic [7:0] pb);
    logic [7:0] porta;
    porta = (pa_out & ddra) | (pa & ~ddra);
    case (reg_e'(r))
      REG_ORB: begin
        drop_flags(8'(1 << FlagCb1));
        return (pb_out & ddrb) | (pb & ~ddrb);
      end
      REG_ORA: begin
        drop_flags(8'(1 << FlagCa1));
        return porta;
      end
      REG_DIR_B: return ddrb;
      REG_DIR_A: return ddra;
      REG_T1_LO: begin
        drop_flags(8'(1 << FlagT1));
        return t1_cnt[7:0];
      end
      REG_T1_HI: return t1_cnt[15:8];
      REG_T1_LAT_LO: return t1_latch[7:0];
      REG_T1_LAT_HI: return t1_latch[15:8];
      REG_T2_LO: begin
        drop_flags(8'(1 << FlagT2));
        return t2_cnt[7:0];
      end
      REG_T2_HI: return t2_cnt[15:8];
      REG_SR:   return sreg;
      REG_ACR:  return acr;
      REG_PCR:  return pcr;
      REG_IFR:  return ifr;
      REG_IER:  return {1'b1, ier};
      default:  return porta;
    endcase
  endfunction

  function automatic void bus_write(logic [3:0] r, logic [7:0] v);
    case (reg_e'(r))
      REG_ORB: begin
        pb_out = v;
        drop_flags(8'(1 << FlagCb1));
      end
      REG_ORA, REG_ORA_NH: begin
        pa_out = v;
        drop_flags(8'(1 << FlagCa1));
      end
      REG_DIR_B: ddrb = v;
      REG_DIR_A: ddra = v;
      REG_T1_LO, REG_T1_LAT_LO: t1_latch[7:0] = v;
      REG_T1_HI: begin
        t1_latch[15:8] = v;
        t1_cnt = t1_latch;
        t1_done = 1'b0;
        drop_flags(8'(1 << FlagT1));
      end
      REG_T1_LAT_HI: begin
        t1_latch[15:8] = v;
        drop_flags(8'(1 << FlagT1));
      end
      REG_T2_LO: t2_lo_latch = v;
      REG_T2_HI: begin
        t2_cnt = {v, t2_lo_latch};
        drop_flags(8'(1 << FlagT2));
      end
      REG_SR:  sreg = v;
      REG_ACR: acr = v;
      REG_PCR: pcr = v;
      REG_IFR: drop_flags(v & 8'h7f);
      default: begin
        if (v[7]) ier = ier | v[6:0];
        else      ier = ier & ~v[6:0];
        update_irq();
      end
    endcase
  endfunction

  // Predict one transaction's result
  function automatic via_result_t predict_result();
    via_result_t res;
    res.rdata = '0;
    case (cmd_e'(cmd_i))
      CMD_READ:  res.rdata = bus_read(reg_index_i, port_a_pins_i, port_b_pins_i);
      CMD_WRITE: bus_write(reg_index_i, write_data_i);
      CMD_TICK:  advance_timers(tick_cycles_i);
      default: begin
        if (ca1_level_i != ca1_prev) begin
          ca1_prev = ca1_level_i;
          if (ca1_level_i == pcr[0]) begin
            ifr[FlagCa1] = 1'b1;
            update_irq();
          end
        end
      end
    endcase
    res.irq = ifr[7];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    via_result_t want;
    if (!rst_ni) begin
      {pa_out, pb_out, ddra, ddrb, t2_lo_latch, sreg, acr, pcr, ifr} = '0;
      ier = '0;
      {t1_cnt, t1_latch, t2_cnt} = '0;
      t1_done = 1'b0;
      ca1_prev = 1'b0;
      errors_o <= 0;
      results_o <= 0;
      pending_o <= 0;
      expected_q.delete();
    end else begin
      // Check the result transaction first; predictions are queued behind
      if (out_valid_i && !out_stall_i) begin
        results_o <= results_o + 1;
        if (expected_q.size() == 0) begin
          if (errors_o < 10) $display("ERROR: unexpected result rd=%h irq=%b",
                                      read_data_i, irq_out_i);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.rdata !== read_data_i || want.irq !== irq_out_i) begin
            if (errors_o < 10)
              $display("ERROR: result mismatch exp rd=%h irq=%b got rd=%h irq=%b",
                       want.rdata, want.irq, read_data_i, irq_out_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(predict_result());
      pending_o <= expected_q.size();
    end
  end

endmodule

>>> tb/testbench.sv
// Testbench top for the versatile interface adapter: clock, reset, stimulus
// and verdict. Depends on via_pkg, versatile_interface_adapter and via_checker.
`timescale 1ns / 1ps
module testbench
  import via_pkg::*;
();

  localparam int unsigned WatchdogLimit = 20000;

  logic       clk_i, rst_ni;
  logic       in_valid, in_stall, out_valid, out_stall;
  logic [1:0] cmd;
  logic [3:0] reg_index;
  logic [7:0] write_data, pa_pins, pb_pins, tick_cycles, read_data;
  logic       ca1_level, irq_out;
  int         errors, pending, results, accepted, idle_cycles;

  versatile_interface_adapter uut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .cmd_i(cmd), .reg_index_i(reg_index), .write_data_i(write_data),
    .port_a_pins_i(pa_pins), .port_b_pins_i(pb_pins),
    .tick_cycles_i(tick_cycles), .ca1_level_i(ca1_level),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .read_data_o(read_data), .irq_out_o(irq_out)
  );

  via_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .cmd_i(cmd), .reg_index_i(reg_index), .write_data_i(write_data),
    .port_a_pins_i(pa_pins), .port_b_pins_i(pb_pins),
    .tick_cycles_i(tick_cycles), .ca1_level_i(ca1_level),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .read_data_i(read_data), .irq_out_i(irq_out),
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  // Offer one transaction and hold it until accepted, then maybe idle
  task automatic send(cmd_e c, reg_e r, logic [7:0] d, logic [7:0] n, logic lvl,
                      bit gaps);
    int unsigned g;
    in_valid    <= 1'b1;
    cmd         <= c;
    reg_index   <= r;
    write_data  <= d;
    pa_pins     <= 8'($urandom);
    pb_pins     <= 8'($urandom);
    tick_cycles <= n;
    ca1_level   <= lvl;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    accepted++;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic wr(reg_e r, logic [7:0] d);
    send(CMD_WRITE, r, d, 8'h00, 1'b0, 1'b0);
  endtask

  task automatic rd(reg_e r);
    send(CMD_READ, r, 8'h00, 8'h00, 1'b0, 1'b0);
  endtask

  task automatic tk(logic [7:0] n);
    send(CMD_TICK, REG_ORB, 8'h00, n, 1'b0, 1'b0);
  endtask

  // Random transaction: 30% reads, 30% writes, 25% ticks, 15% CA1 updates
  task automatic random_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)
      send(CMD_READ, reg_e'($urandom_range(0, 15)), 8'($urandom), 8'($urandom),
           1'($urandom), 1'b1);
    else if (pick < 60)
      send(CMD_WRITE, reg_e'($urandom_range(0, 15)),
           ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom),
           8'($urandom), 1'($urandom), 1'b1);
    else if (pick < 85)
      send(CMD_TICK, reg_e'($urandom_range(0, 15)), 8'($urandom),
           ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 8)) : 8'($urandom),
           1'($urandom), 1'b1);
    else
      send(CMD_CA1, reg_e'($urandom_range(0, 15)), 8'($urandom), 8'($urandom),
           1'($urandom), 1'b1);
  endtask

  // Receiver: random stalls, plus one long hold-off once 150 transactions are accepted
  initial begin
    int unsigned g;
    bit long_done;
    out_stall <= 1'b0;
    long_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!long_done && accepted >= 150) begin
        long_done = 1'b1;
        out_stall <= 1'b1;
        repeat (60) @(posedge clk_i);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        g = gap_len() + 1;
        out_stall <= 1'b1;
        repeat (g) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    in_valid <= 1'b0; cmd <= '0; reg_index <= '0; write_data <= '0;
    pa_pins <= '0; pb_pins <= '0; tick_cycles <= '0; ca1_level <= 1'b0;
    accepted = 0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: ports, direction bits, enable set/clear, flag clearing
    wr(REG_DIR_A, 8'hf0); wr(REG_ORA, 8'hff); rd(REG_ORA); rd(REG_ORA_NH);
    wr(REG_DIR_B, 8'h0f); wr(REG_ORB, 8'haa); rd(REG_ORB);
    wr(REG_IER, 8'hff); rd(REG_IER); wr(REG_IER, 8'h00);
    wr(REG_IER, 8'hff);
    // Zero-cycle tick on a counter at zero, one-shot fires once
    tk(8'd0); rd(REG_IFR); tk(8'd0); rd(REG_T1_LO); tk(8'd255);
    // Free-running with latch 0xffff: period of one
    wr(REG_ACR, 8'h40); wr(REG_T1_LAT_LO, 8'hff); wr(REG_T1_HI, 8'hff); tk(8'hff);
    rd(REG_T1_LO); rd(REG_T1_HI);
    // CA1 edges: falling by default, then rising, then unchanged level
    send(CMD_CA1, REG_ORB, 8'h00, 8'h00, 1'b1, 1'b0);
    send(CMD_CA1, REG_ORB, 8'h00, 8'h00, 1'b0, 1'b0);
    wr(REG_PCR, 8'h01); send(CMD_CA1, REG_ORB, 8'h00, 8'h00, 1'b1, 1'b0);
    send(CMD_CA1, REG_ORB, 8'h00, 8'h00, 1'b1, 1'b0);
    wr(REG_IFR, 8'hff); wr(REG_T2_LO, 8'h05); wr(REG_T2_HI, 8'h00); tk(8'd7);
    wr(REG_SR, 8'h5a); rd(REG_SR); rd(REG_T1_LAT_HI);

    // Random phase, with one long receiver hold-off and one drain pause
    for (int i = 0; i < 400; i++) begin
      if (i == 20 || i == 80 || i == 250) begin
        // program timer 1 free-running or one-shot, latch low byte 0 to 40, high byte 0x00 or 0xff
        wr(REG_ACR, 8'($urandom_range(0, 1) << AcrFreeRun));
        wr(REG_T1_LAT_LO, 8'($urandom_range(0, 40)));
        wr(REG_T1_HI, 8'($urandom_range(0, 1) ? 8'h00 : 8'hff));
      end
      if (i == 300) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
        wait (pending == 0);
        @(posedge clk_i);
      end
      random_item();
    end
    in_valid <= 1'b0;

    @(posedge clk_i);
    wait (pending == 0);
    repeat (40) @(posedge clk_i);
    $display("Covered %0d transactions and %0d results: ports, timers one-shot and",
             accepted, results);
    $display("free-running, CA1 edges, flag and enable registers, long stalls.");
    if (errors == 0 && pending == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> versatile_interface_adapter.f
sv/via_pkg.sv
sv/via_div.sv
sv/versatile_interface_adapter.sv
sv/via_checker.sv
tb/via_checker.sv
tb/testbench.sv
